### src/qrv_pkg.sv
package qrv_pkg;

  localparam int QUAT_W = 16;
  localparam int VEC_W  = 16;
  localparam int MINLEN_W = 15;
  localparam int QFRAC  = QUAT_W - 2;

  // Component products, |q|^2 and the quadratic terms of the rotation.
  localparam int PROD_W = 2 * QUAT_W;
  localparam int S_W    = 2 * QUAT_W + 1;
  localparam int DOT_W  = 2 * QUAT_W + 2;
  localparam int M2_W   = 2 * MINLEN_W;
  // Numerator terms: vector times a dot product, plus doubling headroom.
  localparam int NUM_W  = VEC_W + DOT_W + 2;
  // Rounded dividend 2|N| + den and the doubled divisor.
  localparam int REM_W  = NUM_W + 2;
  localparam int DEN_W  = S_W + 1;

  localparam int LANES  = 3;

  typedef struct packed {
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [VEC_W-1:0]  vec_x;
    logic signed [VEC_W-1:0]  vec_y;
    logic signed [VEC_W-1:0]  vec_z;
  } qin_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [VEC_W-1:0] quo;
    logic             neg;
    logic             ovf;
  } lane_t;

  typedef struct packed {
    logic                  valid;
    logic                  norm;
    logic [DEN_W-1:0]      dv;
    lane_t [LANES-1:0]     lane;
  } dstage_t;

endpackage

### src/qrv_in_if.sv
interface qrv_in_if;
  logic valid;
  logic ready;
  logic signed [qrv_pkg::QUAT_W-1:0] quat_x;
  logic signed [qrv_pkg::QUAT_W-1:0] quat_y;
  logic signed [qrv_pkg::QUAT_W-1:0] quat_z;
  logic signed [qrv_pkg::QUAT_W-1:0] quat_w;
  logic signed [qrv_pkg::VEC_W-1:0]  vec_x;
  logic signed [qrv_pkg::VEC_W-1:0]  vec_y;
  logic signed [qrv_pkg::VEC_W-1:0]  vec_z;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
                  input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
                output ready);
endinterface

### src/qrv_out_if.sv
interface qrv_out_if;
  logic valid;
  logic ready;
  logic signed [qrv_pkg::VEC_W-1:0] rot_x;
  logic signed [qrv_pkg::VEC_W-1:0] rot_y;
  logic signed [qrv_pkg::VEC_W-1:0] rot_z;
  logic                             was_normalized;

  modport source (output valid, rot_x, rot_y, rot_z, was_normalized, input ready);
  modport sink (input valid, rot_x, rot_y, rot_z, was_normalized, output ready);
endinterface

### src/quaternion_rotate_vector.sv
// Channel   Direction  Payload
// item_in   sink       quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z
// rot_out   source     rot_x, rot_y, rot_z, was_normalized
// cfg       write      cfg_we, cfg_data (min_length)
//
// One item enters per cycle unless rot_out stalls; each result passes through
// five arithmetic stages, 17 divider stages and one output register.
// After an overflow-check stage, the divider settles one quotient bit per stage, which sets that depth.
// rst is synchronous and clears the valid bits and sets min_length to 1.
// A stall on rot_out freezes the whole pipeline; item_in.ready drops with it.
module quaternion_rotate_vector (
  input  logic                          clk,
  input  logic                          rst,
  qrv_in_if.sink                        item_in,
  qrv_out_if.source                     rot_out,
  input  logic                          cfg_we,
  input  logic [qrv_pkg::MINLEN_W-1:0]  cfg_data
);

  logic                          en;
  logic [qrv_pkg::MINLEN_W-1:0]  min_length;
  qrv_pkg::qin_t                 din;
  qrv_pkg::dstage_t              front_out, div_out;
  logic [qrv_pkg::VEC_W-1:0]     rot [qrv_pkg::LANES];

  assign en = !rot_out.valid || rot_out.ready;
  assign item_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= qrv_pkg::MINLEN_W'(1);
    end else if (cfg_we) begin
      min_length <= cfg_data;
    end
  end

  assign din.quat_x = item_in.quat_x;
  assign din.quat_y = item_in.quat_y;
  assign din.quat_z = item_in.quat_z;
  assign din.quat_w = item_in.quat_w;
  assign din.vec_x  = item_in.vec_x;
  assign din.vec_y  = item_in.vec_y;
  assign din.vec_z  = item_in.vec_z;

  qrv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (item_in.valid),
    .din        (din),
    .min_length (min_length),
    .dout       (front_out)
  );

  qrv_div u_div (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (front_out),
    .dout (div_out)
  );

  // Saturate the rounded quotient magnitude and apply the sign.
  localparam logic [qrv_pkg::VEC_W-1:0] VMAX = {1'b0, {(qrv_pkg::VEC_W-1){1'b1}}};
  localparam logic [qrv_pkg::VEC_W-1:0] VMIN = {1'b1, {(qrv_pkg::VEC_W-1){1'b0}}};

  always_comb begin
    for (int l = 0; l < qrv_pkg::LANES; l++) begin
      if (div_out.lane[l].neg) begin
        if (div_out.lane[l].ovf || div_out.lane[l].quo > VMIN) begin
          rot[l] = VMIN;
        end else begin
          rot[l] = qrv_pkg::VEC_W'(-div_out.lane[l].quo);
        end
      end else begin
        if (div_out.lane[l].ovf || div_out.lane[l].quo > VMAX) begin
          rot[l] = VMAX;
        end else begin
          rot[l] = div_out.lane[l].quo;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_out.valid <= 1'b0;
    end else if (en) begin
      rot_out.valid <= div_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_out.rot_x          <= rot[0];
      rot_out.rot_y          <= rot[1];
      rot_out.rot_z          <= rot[2];
      rot_out.was_normalized <= div_out.norm;
    end
  end

endmodule

### src/qrv_front.sv
module qrv_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  qrv_pkg::qin_t                   din,
  input  logic [qrv_pkg::MINLEN_W-1:0]    min_length,
  output qrv_pkg::dstage_t                dout
);

  // Stage A: component products.
  logic                                va;
  qrv_pkg::qin_t                       qa;
  logic [qrv_pkg::M2_W-1:0]            m2;
  logic signed [qrv_pkg::PROD_W-1:0]   pxx, pyy, pzz, pww;
  logic signed [qrv_pkg::PROD_W-1:0]   pxv, pyv, pzv;
  logic signed [qrv_pkg::PROD_W-1:0]   pyvz, pzvy, pzvx, pxvz, pxvy, pyvx;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qa   <= din;
      m2   <= qrv_pkg::M2_W'(min_length * min_length);
      pxx  <= qrv_pkg::PROD_W'(din.quat_x * din.quat_x);
      pyy  <= qrv_pkg::PROD_W'(din.quat_y * din.quat_y);
      pzz  <= qrv_pkg::PROD_W'(din.quat_z * din.quat_z);
      pww  <= qrv_pkg::PROD_W'(din.quat_w * din.quat_w);
      pxv  <= qrv_pkg::PROD_W'(din.quat_x * din.vec_x);
      pyv  <= qrv_pkg::PROD_W'(din.quat_y * din.vec_y);
      pzv  <= qrv_pkg::PROD_W'(din.quat_z * din.vec_z);
      pyvz <= qrv_pkg::PROD_W'(din.quat_y * din.vec_z);
      pzvy <= qrv_pkg::PROD_W'(din.quat_z * din.vec_y);
      pzvx <= qrv_pkg::PROD_W'(din.quat_z * din.vec_x);
      pxvz <= qrv_pkg::PROD_W'(din.quat_x * din.vec_z);
      pxvy <= qrv_pkg::PROD_W'(din.quat_x * din.vec_y);
      pyvx <= qrv_pkg::PROD_W'(din.quat_y * din.vec_x);
    end
  end

  // Stage B: |q|^2, w^2 - |u|^2, u.v and u x v.
  logic                               vb;
  qrv_pkg::qin_t                      qb;
  logic                               normb;
  logic [qrv_pkg::S_W-1:0]            sb;
  logic signed [qrv_pkg::S_W-1:0]     ab;
  logic signed [qrv_pkg::DOT_W-1:0]   db;
  logic signed [qrv_pkg::S_W-1:0]     cxb, cyb, czb;
  logic [qrv_pkg::S_W-1:0]            s_sum;

  // All four squares are non-negative, so the bit pattern is the unsigned sum.
  assign s_sum = qrv_pkg::S_W'(qrv_pkg::S_W'(pxx) + qrv_pkg::S_W'(pyy)
               + qrv_pkg::S_W'(pzz) + qrv_pkg::S_W'(pww));

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qb    <= qa;
      sb    <= s_sum;
      normb <= s_sum > qrv_pkg::S_W'(m2);
      ab    <= qrv_pkg::S_W'(pww) - qrv_pkg::S_W'(pxx) - qrv_pkg::S_W'(pyy)
             - qrv_pkg::S_W'(pzz);
      db    <= qrv_pkg::DOT_W'(pxv) + qrv_pkg::DOT_W'(pyv) + qrv_pkg::DOT_W'(pzv);
      cxb   <= qrv_pkg::S_W'(pyvz) - qrv_pkg::S_W'(pzvy);
      cyb   <= qrv_pkg::S_W'(pzvx) - qrv_pkg::S_W'(pxvz);
      czb   <= qrv_pkg::S_W'(pxvy) - qrv_pkg::S_W'(pyvx);
    end
  end

  // Stage C: the three terms of each numerator.
  logic                               vc, normc;
  logic [qrv_pkg::S_W-1:0]            sc;
  logic signed [qrv_pkg::NUM_W-1:0]   txa, txd, txc, tya, tyd, tyc, tza, tzd, tzc;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      normc <= normb;
      sc    <= sb;
      txa   <= qrv_pkg::NUM_W'(qb.vec_x) * qrv_pkg::NUM_W'(ab);
      tya   <= qrv_pkg::NUM_W'(qb.vec_y) * qrv_pkg::NUM_W'(ab);
      tza   <= qrv_pkg::NUM_W'(qb.vec_z) * qrv_pkg::NUM_W'(ab);
      txd   <= qrv_pkg::NUM_W'(qb.quat_x) * qrv_pkg::NUM_W'(db);
      tyd   <= qrv_pkg::NUM_W'(qb.quat_y) * qrv_pkg::NUM_W'(db);
      tzd   <= qrv_pkg::NUM_W'(qb.quat_z) * qrv_pkg::NUM_W'(db);
      txc   <= qrv_pkg::NUM_W'(qb.quat_w) * qrv_pkg::NUM_W'(cxb);
      tyc   <= qrv_pkg::NUM_W'(qb.quat_w) * qrv_pkg::NUM_W'(cyb);
      tzc   <= qrv_pkg::NUM_W'(qb.quat_w) * qrv_pkg::NUM_W'(czb);
    end
  end

  // Stage D: numerators and divisor.
  logic                               vd, normd;
  logic [qrv_pkg::S_W-1:0]            dend;
  logic signed [qrv_pkg::NUM_W-1:0]   nd [qrv_pkg::LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      normd <= normc;
      dend  <= normc ? sc : qrv_pkg::S_W'(1) << (2 * qrv_pkg::QFRAC);
      nd[0] <= txa + (txd <<< 1) + (txc <<< 1);
      nd[1] <= tya + (tyd <<< 1) + (tyc <<< 1);
      nd[2] <= tza + (tzd <<< 1) + (tzc <<< 1);
    end
  end

  // Stage E: sign and magnitude, dividend biased by half the divisor for rounding.
  qrv_pkg::dstage_t e_next;

  always_comb begin
    logic [qrv_pkg::NUM_W-1:0] mag;
    e_next.valid = vd;
    e_next.norm  = normd;
    e_next.dv    = {dend, 1'b0};
    for (int l = 0; l < qrv_pkg::LANES; l++) begin
      mag = nd[l][qrv_pkg::NUM_W-1] ? qrv_pkg::NUM_W'(-nd[l]) : qrv_pkg::NUM_W'(nd[l]);
      e_next.lane[l].neg = nd[l][qrv_pkg::NUM_W-1];
      e_next.lane[l].rem = (qrv_pkg::REM_W'(mag) << 1) + qrv_pkg::REM_W'(dend);
      e_next.lane[l].quo = '0;
      e_next.lane[l].ovf = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= e_next;
    end
  end

endmodule

### src/qrv_div.sv
module qrv_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  qrv_pkg::dstage_t din,
  output qrv_pkg::dstage_t dout
);

  qrv_pkg::dstage_t st [qrv_pkg::VEC_W+1];

  // Stage 0 only detects a quotient too large for the result; each later
  // stage settles one quotient bit, most significant first.
  for (genvar k = 0; k <= qrv_pkg::VEC_W; k++) begin : g_stage
    localparam int SH = (k == 0) ? qrv_pkg::VEC_W : qrv_pkg::VEC_W - k;
    qrv_pkg::dstage_t prev, nxt;

    if (k == 0) begin : g_first
      assign prev = din;
    end else begin : g_next
      assign prev = st[k-1];
    end

    always_comb begin
      logic [qrv_pkg::REM_W-1:0] trial;
      nxt   = prev;
      trial = qrv_pkg::REM_W'(prev.dv) << SH;
      for (int l = 0; l < qrv_pkg::LANES; l++) begin
        if (prev.lane[l].rem >= trial) begin
          if (k == 0) begin
            nxt.lane[l].ovf = 1'b1;
          end else begin
            nxt.lane[l].rem = prev.lane[l].rem - trial;
            nxt.lane[l].quo = prev.lane[l].quo | (qrv_pkg::VEC_W'(1) << SH);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[k].valid <= 1'b0;
      end else if (en) begin
        st[k] <= nxt;
      end
    end
  end

  assign dout = st[qrv_pkg::VEC_W];

endmodule

### src/qrv_checker.sv
module qrv_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [qrv_pkg::VEC_W-1:0] rot_x,
  input logic was_normalized
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(rot_x) && $stable(was_normalized))
    else $error("result changed while stalled");

  // The input side is only held back while a result waits downstream.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output stall");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind quaternion_rotate_vector qrv_checker u_qrv_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (item_in.ready),
  .out_valid      (rot_out.valid),
  .out_ready      (rot_out.ready),
  .rot_x          (rot_out.rot_x),
  .was_normalized (rot_out.was_normalized)
);
